FILE: rtl/kfbl_pkg.sv
// ----------------------------------------------------------------------------
// kfbl_pkg: shared types and constants for the keyword file byte lexer
// Holds the payload structs, token and lexer state codes and character codes.
// ----------------------------------------------------------------------------
package kfbl_pkg;

  localparam int LINE_BITS = 24;

  // character codes
  localparam logic [7:0] CH_NEWLINE  = 8'h0a;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_VT       = 8'h0b;
  localparam logic [7:0] CH_FF       = 8'h0c;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_ASTERISK = 8'h2a;
  localparam logic [7:0] CH_PLUS     = 8'h2b;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_DOT      = 8'h2e;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UPPER_E  = 8'h45;
  localparam logic [7:0] CH_LOWER_E  = 8'h65;

  typedef enum logic [2:0] {
    TOK_SPACE    = 3'd0,
    TOK_NEWLINE  = 3'd1,
    TOK_COMMA    = 3'd2,
    TOK_ASTERISK = 3'd3,
    TOK_WORD     = 3'd4,
    TOK_NUMBER   = 3'd5,
    TOK_END      = 3'd6,
    TOK_COMMENT  = 3'd7
  } tok_kind_t;

  typedef enum logic [2:0] {
    OPEN_NONE    = 3'd0,
    OPEN_SPACE   = 3'd1,
    OPEN_WORD    = 3'd2,
    OPEN_NUMBER  = 3'd3,
    OPEN_COMMENT = 3'd4
  } open_kind_t;

  typedef enum logic [2:0] {
    NUM_INTEGER  = 3'd0,
    NUM_FRACTION = 3'd1,
    NUM_MARK     = 3'd2,
    NUM_SIGN     = 3'd3,
    NUM_EXPONENT = 3'd4
  } num_phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    tok_kind_t              token_kind;
    logic                   token_start;
    logic [LINE_BITS-1:0]   line_number;
  } out_item_t;

  typedef struct packed {
    logic                 at_line_start;
    open_kind_t           open_kind;
    num_phase_t           number_phase;
    logic [LINE_BITS-1:0] line_counter;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    at_line_start: 1'b1,
    open_kind:     OPEN_NONE,
    number_phase:  NUM_INTEGER,
    line_counter:  LINE_BITS'(1)
  };

endpackage

FILE: rtl/kfbl_step.sv
// ----------------------------------------------------------------------------
// kfbl_step: per-byte lexer rule
// Combinational next state and result for one byte against the lexer state.
// ----------------------------------------------------------------------------
module kfbl_step import kfbl_pkg::*; (
  input  lex_state_t cur_state,
  input  in_item_t   item,
  output lex_state_t nxt_state,
  output out_item_t  result
);

  logic [7:0]           c;
  logic                 is_digit;
  logic                 is_run_space;
  logic                 is_start_space;
  logic                 is_exp;
  logic                 is_sign;
  logic                 num_takes;
  num_phase_t           num_phase_nxt;
  logic                 cont;
  logic [LINE_BITS-1:0] line_inc;

  assign c              = item.text_byte;
  assign is_digit       = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_start_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  assign is_run_space   = is_start_space || (c == CH_CR);
  assign is_exp         = (c == CH_LOWER_E) || (c == CH_UPPER_E);
  assign is_sign        = (c == CH_PLUS) || (c == CH_MINUS);
  assign line_inc       = (&cur_state.line_counter) ? cur_state.line_counter
                                                    : cur_state.line_counter + 1'b1;

  // number phase transitions
  always_comb begin
    num_takes     = 1'b0;
    num_phase_nxt = cur_state.number_phase;
    case (cur_state.number_phase)
      NUM_INTEGER: begin
        if (is_digit) begin
          num_takes = 1'b1;
        end else if (c == CH_DOT) begin
          num_takes = 1'b1; num_phase_nxt = NUM_FRACTION;
        end else if (is_exp) begin
          num_takes = 1'b1; num_phase_nxt = NUM_MARK;
        end else if (is_sign) begin
          num_takes = 1'b1; num_phase_nxt = NUM_SIGN;
        end
      end
      NUM_FRACTION: begin
        if (is_digit) begin
          num_takes = 1'b1;
        end else if (is_exp) begin
          num_takes = 1'b1; num_phase_nxt = NUM_MARK;
        end else if (is_sign) begin
          num_takes = 1'b1; num_phase_nxt = NUM_SIGN;
        end
      end
      NUM_MARK: begin
        if (is_sign) begin
          num_takes = 1'b1; num_phase_nxt = NUM_SIGN;
        end else if (is_digit) begin
          num_takes = 1'b1; num_phase_nxt = NUM_EXPONENT;
        end
      end
      NUM_SIGN, NUM_EXPONENT: begin
        if (is_digit) begin
          num_takes = 1'b1; num_phase_nxt = NUM_EXPONENT;
        end
      end
      default: begin
        num_takes = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt_state          = cur_state;
    result.token_kind  = TOK_WORD;
    result.token_start = 1'b0;
    result.line_number = cur_state.line_counter;
    cont               = 1'b0;

    if (item.end_of_input) begin
      // an open comment counts its line before the reset
      if (cur_state.open_kind == OPEN_COMMENT) begin
        result.line_number = line_inc;
      end
      result.token_kind  = TOK_END;
      result.token_start = 1'b1;
      nxt_state          = LEX_RESET;
    end else begin
      case (cur_state.open_kind)
        OPEN_COMMENT: begin
          cont              = 1'b1;
          result.token_kind = TOK_COMMENT;
          if (c == CH_NEWLINE) begin
            nxt_state.line_counter = line_inc;
            nxt_state.open_kind    = OPEN_NONE;
          end
        end
        OPEN_SPACE: begin
          if (is_run_space) begin
            cont              = 1'b1;
            result.token_kind = TOK_SPACE;
          end
        end
        OPEN_WORD: begin
          if ((c != CH_NEWLINE) && !is_run_space) begin
            cont              = 1'b1;
            result.token_kind = TOK_WORD;
          end
        end
        OPEN_NUMBER: begin
          if (num_takes) begin
            cont                   = 1'b1;
            result.token_kind      = TOK_NUMBER;
            nxt_state.number_phase = num_phase_nxt;
          end
        end
        default: begin
          cont = 1'b0;
        end
      endcase

      if (!cont) begin
        // byte begins a new token
        result.token_start  = 1'b1;
        nxt_state.open_kind = OPEN_NONE;
        if (c == CH_NEWLINE) begin
          result.token_kind       = TOK_NEWLINE;
          nxt_state.at_line_start = 1'b1;
          nxt_state.line_counter  = line_inc;
        end else if (cur_state.at_line_start && (c == CH_DOLLAR)) begin
          result.token_kind   = TOK_COMMENT;
          nxt_state.open_kind = OPEN_COMMENT;
        end else if (cur_state.at_line_start && (c == CH_ASTERISK)) begin
          result.token_kind       = TOK_ASTERISK;
          nxt_state.at_line_start = 1'b0;
        end else if (cur_state.at_line_start && (c == CH_COMMA)) begin
          result.token_kind = TOK_COMMA;
        end else if (is_start_space) begin
          result.token_kind       = TOK_SPACE;
          nxt_state.at_line_start = 1'b0;
          nxt_state.open_kind     = OPEN_SPACE;
        end else if (is_digit || (c == CH_MINUS)) begin
          // numbers leave the line start rules in force
          result.token_kind      = TOK_NUMBER;
          nxt_state.open_kind    = OPEN_NUMBER;
          nxt_state.number_phase = NUM_INTEGER;
        end else begin
          result.token_kind       = TOK_WORD;
          nxt_state.at_line_start = 1'b0;
          nxt_state.open_kind     = OPEN_WORD;
        end
      end
    end
  end

endmodule

FILE: rtl/keyword_file_byte_lexer_core.sv
// ----------------------------------------------------------------------------
// keyword_file_byte_lexer_core: byte lexer for keyword text files
// Labels each text byte with its token kind, token start and line number.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+----------------------------------
//  input   | in_valid, in_ready, in_data    | text_byte, end_of_input
//  result  | out_valid, out_ready, out_data | token_kind, token_start, line_number
//
//  one byte per cycle sustained while out_ready holds no result back; each byte goes:
//  input register, then the lexer rule into the result register
//  the lexer state advances when a byte moves from input to result register
//  rst_n clears the valid flags and the lexer state (line 1, line start)
//  a stalled result keeps one byte held in the input register
// ----------------------------------------------------------------------------
module keyword_file_byte_lexer_core import kfbl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  lex_state_t state_r;
  lex_state_t state_nxt;
  out_item_t  result_nxt;
  logic       advance;

  kfbl_step u_step (
    .cur_state (state_r),
    .item      (in_item_r),
    .nxt_state (state_nxt),
    .result    (result_nxt)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= LEX_RESET;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result_nxt;
    end
  end

  // line counter starts at one and saturates, never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.line_counter != '0)
    else $error("line counter reached zero");

  // end of input returns the lexer to its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.end_of_input) |=>
      (state_r.at_line_start && (state_r.open_kind == OPEN_NONE) &&
       (state_r.line_counter == LINE_BITS'(1))))
    else $error("lexer not reset after end of input");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a held result");

  // a new result only appears from a byte that was waiting in the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result without a pending byte");

  // an end token always starts a token
  a_end_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.token_kind == TOK_END)) |-> out_item_r.token_start)
    else $error("end token without token start");

endmodule

FILE: bench/kfbl_lex_checker.sv
// ----------------------------------------------------------------------------
// kfbl_lex_checker: result checker for the keyword file byte lexer
// Watches both channels, predicts the token label of every accepted byte and
// compares each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module kfbl_lex_checker import kfbl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        error_count,
  output int        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic                 at_bol;
  open_kind_t           open_tok;
  num_phase_t           num_phase;
  logic [LINE_BITS-1:0] line_cnt;

  out_item_t expected_tokens [$];
  out_item_t want;
  int        mismatches = 0;
  int        pending = 0;

  assign error_count   = mismatches;
  assign pending_count = pending;

  function void clear_lexer();
    at_bol    = 1'b1;
    open_tok  = OPEN_NONE;
    num_phase = NUM_INTEGER;
    line_cnt  = LINE_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_up(input logic [LINE_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic out_item_t make_token(input tok_kind_t kind, input logic start,
                                           input logic [LINE_BITS-1:0] ln);
    out_item_t t;
    t.token_kind  = kind;
    t.token_start = start;
    t.line_number = ln;
    return t;
  endfunction

  function automatic out_item_t lex_byte(input in_item_t item);
    logic [7:0]           c;
    logic                 dig;
    logic                 expo;
    logic                 sgn;
    logic                 run_sp;
    logic                 start_sp;
    logic                 takes;
    logic [LINE_BITS-1:0] ln;
    c        = item.text_byte;
    ln       = line_cnt;
    dig      = (c >= CH_ZERO) && (c <= CH_NINE);
    expo     = (c == CH_LOWER_E) || (c == CH_UPPER_E);
    sgn      = (c == CH_PLUS) || (c == CH_MINUS);
    start_sp = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    run_sp   = start_sp || (c == CH_CR);
    takes    = 1'b0;

    if (item.end_of_input) begin
      if (open_tok == OPEN_COMMENT) ln = line_up(ln);
      clear_lexer();
      return make_token(TOK_END, 1'b1, ln);
    end

    case (open_tok)
      OPEN_COMMENT: begin
        if (c == CH_NEWLINE) begin
          line_cnt = line_up(line_cnt);
          open_tok = OPEN_NONE;
        end
        return make_token(TOK_COMMENT, 1'b0, ln);
      end
      OPEN_SPACE: begin
        if (run_sp) return make_token(TOK_SPACE, 1'b0, ln);
      end
      OPEN_WORD: begin
        if (c != CH_NEWLINE && !run_sp) return make_token(TOK_WORD, 1'b0, ln);
      end
      OPEN_NUMBER: begin
        case (num_phase)
          NUM_INTEGER: begin
            if (dig) takes = 1'b1;
            else if (c == CH_DOT) begin num_phase = NUM_FRACTION; takes = 1'b1; end
            else if (expo) begin num_phase = NUM_MARK; takes = 1'b1; end
            else if (sgn) begin num_phase = NUM_SIGN; takes = 1'b1; end
          end
          NUM_FRACTION: begin
            if (dig) takes = 1'b1;
            else if (expo) begin num_phase = NUM_MARK; takes = 1'b1; end
            else if (sgn) begin num_phase = NUM_SIGN; takes = 1'b1; end
          end
          NUM_MARK: begin
            if (sgn) begin num_phase = NUM_SIGN; takes = 1'b1; end
            else if (dig) begin num_phase = NUM_EXPONENT; takes = 1'b1; end
          end
          NUM_SIGN, NUM_EXPONENT: begin
            if (dig) begin num_phase = NUM_EXPONENT; takes = 1'b1; end
          end
          default: takes = 1'b0;
        endcase
        if (takes) return make_token(TOK_NUMBER, 1'b0, ln);
      end
      default: ;
    endcase
    open_tok = OPEN_NONE;

    // byte starts a new token
    if (c == CH_NEWLINE) begin
      at_bol   = 1'b1;
      line_cnt = line_up(line_cnt);
      return make_token(TOK_NEWLINE, 1'b1, ln);
    end
    if (at_bol) begin
      if (c == CH_DOLLAR) begin
        open_tok = OPEN_COMMENT;
        return make_token(TOK_COMMENT, 1'b1, ln);
      end
      if (c == CH_ASTERISK) begin
        at_bol = 1'b0;
        return make_token(TOK_ASTERISK, 1'b1, ln);
      end
      if (c == CH_COMMA) return make_token(TOK_COMMA, 1'b1, ln);
    end
    if (start_sp) begin
      at_bol   = 1'b0;
      open_tok = OPEN_SPACE;
      return make_token(TOK_SPACE, 1'b1, ln);
    end
    if (dig || c == CH_MINUS) begin
      open_tok  = OPEN_NUMBER;
      num_phase = NUM_INTEGER;
      return make_token(TOK_NUMBER, 1'b1, ln);
    end
    // carriage return lands here too when it has to open a token
    at_bol   = 1'b0;
    open_tok = OPEN_WORD;
    return make_token(TOK_WORD, 1'b1, ln);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: result transaction with nothing expected, got kind %0d start %0d line %0d",
                   $time, out_data.token_kind, out_data.token_start, out_data.line_number);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind) begin
            $display("%0t: token_kind expected %0d got %0d",
                     $time, want.token_kind, out_data.token_kind);
            mismatches++;
          end
          if (out_data.token_start !== want.token_start) begin
            $display("%0t: token_start expected %0d got %0d",
                     $time, want.token_start, out_data.token_start);
            mismatches++;
          end
          if (out_data.line_number !== want.line_number) begin
            $display("%0t: line_number expected %0d got %0d",
                     $time, want.line_number, out_data.line_number);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_tokens.insert(expected_tokens.size(), lex_byte(in_data));
      end
    end
    pending = expected_tokens.size();
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for keyword_file_byte_lexer_core
// Feeds directed bytes and then random keyword-file lines under several
// idle/stall mixes, with one long receiver hold-off; the checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module tb;
  import kfbl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          BYTES_PER_PHASE = 213;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int          error_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  int          sent_bytes = 0;
  int unsigned cycle_count = 0;

  // directed opening: comment line, line-start comma and asterisk, whitespace
  // kinds, all number phases, carriage return opening a word, extreme bytes
  logic [7:0] opening_text [23] = '{
    CH_DOLLAR, "x", CH_NEWLINE, CH_COMMA, CH_ASTERISK, "k", CH_COMMA, CH_SPACE,
    CH_TAB, CH_CR, CH_VT, CH_FF, CH_MINUS, "1", CH_DOT, "5", CH_UPPER_E,
    CH_MINUS, "7", CH_CR, CH_NEWLINE, 8'hff, 8'h00
  };

  keyword_file_byte_lexer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  kfbl_lex_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL keyword_file_byte_lexer_core");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t item;
    item.text_byte    = c;
    item.end_of_input = 1'b0;
    send_item(item);
  endtask

  task automatic send_eoi();
    in_item_t item;
    item.text_byte    = 8'($urandom_range(0, 255));
    item.end_of_input = 1'b1;
    send_item(item);
  endtask

  task automatic send_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_word();
    repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(33, 126)));
  endtask

  task automatic send_number();
    logic minus;
    minus = ($urandom_range(0, 2) == 0);
    if (minus) send_char(CH_MINUS);
    send_digits(minus ? 0 : 1, 4);
    if ($urandom_range(0, 1) == 0) begin
      send_char(CH_DOT);
      send_digits(0, 3);
    end
    if ($urandom_range(0, 9) < 4) begin
      send_char($urandom_range(0, 1) ? CH_UPPER_E : CH_LOWER_E);
      if ($urandom_range(0, 9) < 6) send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      send_digits(0, 3);
    end else if ($urandom_range(0, 9) == 0) begin
      // sign straight after the mantissa
      send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      send_digits(0, 2);
    end
  endtask

  task automatic send_data_line();
    int fields;
    fields = $urandom_range(1, 6);
    if ($urandom_range(0, 3) == 0) send_char(CH_SPACE);
    if ($urandom_range(0, 5) == 0) send_char(CH_COMMA);
    for (int i = 0; i < fields; i++) begin
      if (i > 0) begin
        case ($urandom_range(0, 3))
          0: send_char(CH_COMMA);
          1: begin
            send_char(CH_COMMA);
            send_char(CH_SPACE);
          end
          2: repeat ($urandom_range(1, 4)) send_char(CH_SPACE);
          default: send_char(CH_TAB);
        endcase
      end
      send_number();
    end
    // numbers and commas keep the line start rules, so a dollar may still open a comment
    if ($urandom_range(0, 7) == 0) begin
      send_char(CH_DOLLAR);
      send_word();
    end
    if ($urandom_range(0, 3) == 0) send_char(CH_CR);
    send_char(CH_NEWLINE);
  endtask

  task automatic send_random_line();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      send_char(CH_DOLLAR);
      repeat ($urandom_range(0, 10)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_NEWLINE);
    end else if (pick < 30) begin
      send_char(CH_ASTERISK);
      send_word();
      if ($urandom_range(0, 1) == 0) begin
        send_char(CH_SPACE);
        send_word();
      end
      send_char(CH_NEWLINE);
    end else if (pick < 70) begin
      send_data_line();
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      // malformed number tail
      send_number();
      send_char(8'($urandom_range(33, 126)));
      send_char(CH_NEWLINE);
    end else begin
      send_eoi();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_text[i]) send_char(opening_text[i]);
    send_eoi();
    send_char(CH_DOLLAR);
    send_eoi();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // long receiver hold-off while bytes keep coming
          in_valid <= 1'b0;
          @(posedge clk);
          hold_left = 60;
          @(negedge clk);
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 58;
        end
        default: begin
          send_idle_pct = 24;
          recv_idle_pct = 24;
        end
      endcase
      begin
        int target;
        target = sent_bytes + BYTES_PER_PHASE;
        while (sent_bytes < target) send_random_line();
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS keyword_file_byte_lexer_core");
    end else begin
      $display("FAIL keyword_file_byte_lexer_core");
    end
    $finish;
  end

endmodule

FILE: keyword_file_byte_lexer_core.f
rtl/kfbl_pkg.sv
rtl/kfbl_step.sv
rtl/keyword_file_byte_lexer_core.sv
bench/kfbl_lex_checker.sv
bench/tb.sv
